@@ rtl/u8cp_pkg.sv @@
// Constants, code-page table and code point mapping functions for the
// UTF-8 to CP1251 transcoder. No dependencies.
package u8cp_pkg;

   // Replacement character for anything that cannot be mapped
   localparam logic [7:0] CHAR_QMARK = 8'h3F;

   // Count of lead/second bytes held for a pending sequence
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_LEAD = 2'd1;
   localparam logic [1:0] HELD_TWO  = 2'd2;

   // Bytes dropped after a four-byte lead
   localparam logic [1:0] SKIP_FOUR = 2'd3;

   // Number of result slots per request
   localparam int unsigned RES_SLOTS = 3;

   typedef logic [7:0] char_type;
   typedef char_type   res_arr_type [RES_SLOTS];

   // U+0400..U+040F, other than U+0401, map through this table
   localparam char_type LOW_CYR_TAB [16] = '{
      8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
      8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF
   };

   // Map an 11-bit code point from a two-byte sequence
   function automatic char_type map_two(input logic [10:0] cp);
      char_type res;
      res = CHAR_QMARK;
      priority if (cp >= 11'h410 && cp <= 11'h44F) begin
         res = 8'hC0 + 8'(cp - 11'h410);
      end else if (cp == 11'h401) begin
         res = 8'hA8;
      end else if (cp == 11'h451) begin
         res = 8'hB8;
      end else if (cp >= 11'h400 && cp <= 11'h40F) begin
         res = LOW_CYR_TAB[cp[3:0]];
      end else if (cp >= 11'h0A0 && cp <= 11'h0BF) begin
         res = cp[7:0];
      end else begin
         res = CHAR_QMARK;
      end
      return res;
   endfunction

   // Map a 16-bit code point from a three-byte sequence
   function automatic char_type map_three(input logic [15:0] cp);
      char_type res;
      res = CHAR_QMARK;
      priority if (cp == 16'h2013 || cp == 16'h2014) begin
         res = 8'h2D;
      end else if (cp == 16'h2018 || cp == 16'h2019) begin
         res = 8'h27;
      end else if (cp == 16'h201C || cp == 16'h201D) begin
         res = 8'h22;
      end else if (cp == 16'h2022) begin
         res = 8'h95;
      end else if (cp == 16'h2026) begin
         res = 8'h2E;
      end else if (cp == 16'h00AB || cp == 16'h00BB) begin
         res = 8'h22;
      end else if (cp >= 16'h0450 && cp <= 16'h045F) begin
         res = 8'h90 + {4'h0, cp[3:0]};
      end else begin
         res = CHAR_QMARK;
      end
      return res;
   endfunction

endpackage

@@ rtl/utf8_to_cp1251_transcoder.sv @@
// Top level of the UTF-8 to CP1251 transcoder: input register, decode
// logic and a three-slot result buffer. Depends on u8cp_pkg.
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | req_in_byte, req_end_of_text
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_out_char, rsp_last_of_run
//
// A request is taken into the input register, decoded combinationally and
// its zero to three result characters are loaded into the result buffer.
// One request per cycle while each gives at most one result and the result
// side does not stall; with more results, the next waits for the last one.
// Reset is synchronous and clears held bytes, skip count and all valids.
// A stall on the result side holds the buffer; the input register still
// takes one more request behind it.
module utf8_to_cp1251_transcoder
   import u8cp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   // Input register
   logic     in_vld_ff;
   char_type in_byte_ff;
   logic     in_eot_ff;

   // Decoder state
   char_type lead_ff, lead_in;
   char_type second_ff, second_in;
   logic [1:0] held_ff, held_in;
   logic [1:0] skip_ff, skip_in;

   // Result buffer
   res_arr_type res_ff;
   res_arr_type res_in;
   logic [1:0]  cnt_ff;
   logic [1:0]  cnt_in;
   logic        last_ff;

   logic take_in;
   logic rsp_take;
   logic proc;

   // Decode intermediates
   logic [1:0] pre_q;
   logic [1:0] post_q;
   logic       main_put;
   char_type   main_char;
   logic       do_lead;
   logic [2:0] res_sum;

   assign rsp_take  = rsp_valid && !rsp_stall;
   assign proc      = in_vld_ff && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && rsp_take));
   assign req_stall = in_vld_ff && !proc;
   assign take_in   = req_valid && !req_stall;

   // Hold the next request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (take_in) begin
         in_vld_ff <= 1'b1;
      end else if (proc) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_byte_ff <= req_in_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   // Decode one byte: skip, flush, main character, end-of-text flush
   always_comb begin
      lead_in   = lead_ff;
      second_in = second_ff;
      held_in   = held_ff;
      skip_in   = skip_ff;
      pre_q     = 2'd0;
      post_q    = 2'd0;
      main_put  = 1'b0;
      main_char = CHAR_QMARK;
      do_lead   = 1'b0;

      priority if (skip_ff != 2'd0) begin
         skip_in = skip_ff - 2'd1;
      end else if (held_ff == HELD_NONE) begin
         do_lead = 1'b1;
      end else if (in_byte_ff[7:6] != 2'b10) begin
         pre_q   = (held_ff == HELD_LEAD) ? 2'd1 : 2'd2;
         held_in = HELD_NONE;
         do_lead = 1'b1;
      end else if (held_ff == HELD_LEAD && lead_ff[7:5] == 3'b110) begin
         main_put  = 1'b1;
         main_char = map_two({lead_ff[4:0], in_byte_ff[5:0]});
         held_in   = HELD_NONE;
      end else if (held_ff == HELD_LEAD) begin
         second_in = in_byte_ff;
         held_in   = HELD_TWO;
      end else begin
         main_put  = 1'b1;
         main_char = map_three({lead_ff[3:0], second_ff[5:0], in_byte_ff[5:0]});
         held_in   = HELD_NONE;
      end

      // Start a new sequence
      if (do_lead) begin
         priority if (!in_byte_ff[7]) begin
            main_put  = 1'b1;
            main_char = in_byte_ff;
         end else if (in_byte_ff[7:5] == 3'b110 || in_byte_ff[7:4] == 4'b1110) begin
            lead_in = in_byte_ff;
            held_in = HELD_LEAD;
         end else if (in_byte_ff[7:3] == 5'b11110) begin
            main_put = 1'b1;
            skip_in  = SKIP_FOUR;
         end else begin
            main_put = 1'b1;
         end
      end

      // Flush anything still held at the end of the text, one '?' per byte
      if (in_eot_ff) begin
         post_q  = (held_in == HELD_NONE) ? 2'd0 :
                   (held_in == HELD_LEAD) ? 2'd1 : 2'd2;
         held_in = HELD_NONE;
         skip_in = 2'd0;
      end

      res_sum = {1'b0, pre_q} + {2'b00, main_put} + {1'b0, post_q};

      // Every slot is '?' except the main character, which follows the flush
      for (int i = 0; i < RES_SLOTS; i++) begin
         res_in[i] = (main_put && pre_q == 2'(i)) ? main_char : CHAR_QMARK;
      end
   end

   // Advance decoder state on each processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff   <= 8'h00;
         second_ff <= 8'h00;
         held_ff   <= HELD_NONE;
         skip_ff   <= 2'd0;
      end else if (proc) begin
         lead_ff   <= lead_in;
         second_ff <= second_in;
         held_ff   <= held_in;
         skip_ff   <= skip_in;
      end
   end

   // Load the result buffer, or shift it as results are taken
   always_comb begin
      cnt_in = cnt_ff;
      if (proc) begin
         cnt_in = res_sum[1:0];
      end else if (rsp_take) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         res_ff  <= res_in;
         last_ff <= in_eot_ff;
      end else if (rsp_take) begin
         res_ff[0] <= res_ff[1];
         res_ff[1] <= res_ff[2];
      end
   end

   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_out_char    = res_ff[0];
   assign rsp_last_of_run = last_ff && (cnt_ff == 2'd1);

   // A skip only follows a four-byte lead, which leaves nothing held
   a_skip_no_held: assert property (@(posedge clock) disable iff (reset)
      (skip_ff != 2'd0) |-> (held_ff == HELD_NONE))
      else $error("skip pending while bytes are held");

   // The held count never exceeds two bytes
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff != 2'd3)
      else $error("held count out of range");

   // End of text leaves a clean decoder
   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (proc && in_eot_ff) |=> (held_ff == HELD_NONE && skip_ff == 2'd0))
      else $error("decoder state left over after end of text");

   // The buffer is only reloaded once it is empty or emptying
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      proc |-> (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && !rsp_stall)))
      else $error("result buffer overwritten");

endmodule
